@@ rtl/oriented_box_corners_top_defines.svh @@
// Assertion macros shared by the RTL. Each expects clock and reset in scope.
`ifndef ORIENTED_BOX_CORNERS_TOP_DEFINES_SVH
`define ORIENTED_BOX_CORNERS_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/obc_pkg.sv @@
`timescale 1ns / 1ps
package obc_pkg;
   localparam int ANGLE_BITS     = 16;
   localparam int COORD_BITS     = 32;
   localparam int TRIG_FRAC_BITS = 14;

   localparam int DATA_W  = 32;
   localparam int ANGLE_W = 16;
   localparam int TURN_W  = 32;
   localparam int CW      = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam int MW      = TRIG_FRAC_BITS + 2;
   localparam int HW      = DATA_W + 2;
   localparam int SUM_W   = HW + 2;

   localparam int SIN_STAGES   = 7;
   localparam int FRONT_STAGES = SIN_STAGES + 3;

   localparam int SIN_SH = (TRIG_FRAC_BITS < 30) ? 30 - TRIG_FRAC_BITS : 0;
   localparam logic [30:0] SIN_HALF = 31'((64'd1 << SIN_SH) >> 1);
   localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
   localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [30:0] SIN_COEF [0:4] = '{
      31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
   };

   localparam logic [2:0] LAST_K = 3'd7;
   // Bit j is set where the corner lies on the positive side of object axis j.
   localparam logic [2:0] CORNER_POS [0:7] = '{
      3'b000, 3'b001, 3'b011, 3'b010, 3'b100, 3'b101, 3'b111, 3'b110
   };

   typedef logic signed [DATA_W-1:0] coord_type;
   typedef logic signed [MW-1:0]     entry_type;
   typedef logic signed [HW-1:0]     half_type;

   typedef struct packed {
      coord_type                 center_x;
      coord_type                 center_y;
      coord_type                 center_z;
      logic signed [ANGLE_W-1:0] yaw_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] roll_angle;
      logic [DATA_W-1:0]         box_length;
      logic [DATA_W-1:0]         box_width;
      logic [DATA_W-1:0]         box_height;
   } req_type;

   typedef struct packed {
      logic [2:0] corner_index;
      coord_type  corner_x;
      coord_type  corner_y;
      coord_type  corner_z;
      coord_type  bound_x_min;
      coord_type  bound_x_max;
      coord_type  bound_y_min;
      coord_type  bound_y_max;
      coord_type  bound_z_min;
      coord_type  bound_z_max;
      logic       last_corner;
      logic       saturated;
   } rsp_type;

   typedef struct packed {
      coord_type [2:0] ctr;
      half_type  [8:0] h;
   } box_type;

   function automatic logic [TURN_W-1:0] turn_of(input logic [ANGLE_W-1:0] a);
      logic [TURN_W-1:0] u;
      u = {a, 16'd0};
      return u & ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
   endfunction
endpackage

@@ rtl/obc_if.sv @@
`timescale 1ns / 1ps
interface obc_req_if;
   import obc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface obc_rsp_if;
   import obc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/obc_sin.sv @@
`timescale 1ns / 1ps
module obc_sin (
   input  logic                          clock,
   input  logic [obc_pkg::SIN_STAGES-1:0] stage_en,
   input  logic [obc_pkg::TURN_W-1:0]    turn,
   output obc_pkg::entry_type            sin_out
);
   import obc_pkg::*;

   localparam int MAGW = TRIG_FRAC_BITS + 1;

   logic [1:0]  quad_ff [0:5];
   logic [30:0] t_ff    [0:5];
   logic [30:0] t2_ff   [1:4];
   logic [30:0] p_ff    [2:5];
   logic [30:0] t_in;
   logic [61:0] sq_prod;
   logic [61:0] s_prod;
   logic [31:0] s_raw;
   logic [30:0] s_cap;
   logic [31:0] s_rnd;
   logic [MAGW-1:0] s_mag;
   entry_type   sin_ff;

   always_comb begin
      t_in    = turn[30] ? ONE_Q30 - {1'b0, turn[29:0]} : {1'b0, turn[29:0]};
      sq_prod = {31'd0, t_ff[0]} * {31'd0, t_ff[0]};
      s_prod  = {31'd0, p_ff[5]} * {31'd0, t_ff[5]};
      s_raw   = s_prod[61:30];
      s_cap   = (s_raw > {1'b0, ONE_Q30}) ? ONE_Q30 : s_raw[30:0];
      s_rnd   = {1'b0, s_cap} + {1'b0, SIN_HALF};
      s_mag   = MAGW'(s_rnd >> SIN_SH);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         quad_ff[0] <= turn[31:30];
         t_ff[0]    <= t_in;
      end
      if (stage_en[1]) begin
         quad_ff[1] <= quad_ff[0];
         t_ff[1]    <= t_ff[0];
         t2_ff[1]   <= sq_prod[60:30];
      end
      if (stage_en[6]) begin
         sin_ff <= quad_ff[5][1] ? -entry_type'({1'b0, s_mag}) : entry_type'({1'b0, s_mag});
      end
   end

   for (genvar n = 2; n <= 5; n++) begin : g_horner
      logic [61:0] prod;
      if (n == 2) begin : g_first
         assign prod = {31'd0, SIN_COEF[0]} * {31'd0, t2_ff[1]};
      end else begin : g_next
         assign prod = {31'd0, p_ff[n-1]} * {31'd0, t2_ff[n-1]};
      end
      always_ff @(posedge clock) begin
         if (stage_en[n]) begin
            quad_ff[n] <= quad_ff[n-1];
            t_ff[n]    <= t_ff[n-1];
            p_ff[n]    <= SIN_COEF[n-1] - prod[60:30];
            if (n < 5) begin
               t2_ff[(n < 5) ? n : 4] <= t2_ff[n-1];
            end
         end
      end
   end

   assign sin_out = sin_ff;
endmodule

@@ rtl/obc_matrix.sv @@
`timescale 1ns / 1ps
module obc_matrix (
   input  logic             clock,
   input  logic             reset,
   obc_req_if.sink          req,
   output logic             box_valid,
   input  logic             box_ready,
   output obc_pkg::box_type box
);
   import obc_pkg::*;

   localparam int PW = 2 * MW;
   localparam logic [PW-1:0] RND = PW'(1) << (TRIG_FRAC_BITS - 1);
   localparam int AW = MW + DATA_W + 1;
   localparam logic [AW-1:0] HALF_RND = AW'(1) << TRIG_FRAC_BITS;
   localparam int M1 = SIN_STAGES;
   localparam int M2 = SIN_STAGES + 1;
   localparam int M3 = SIN_STAGES + 2;

   function automatic entry_type rmul(input entry_type a, input entry_type b);
      logic signed [PW-1:0] p;
      logic [PW-1:0]        mag;
      p   = a * b;
      mag = p[PW-1] ? PW'(-p) : PW'(p);
      mag = (mag + RND) >> TRIG_FRAC_BITS;
      return p[PW-1] ? -entry_type'(mag) : entry_type'(mag);
   endfunction

   function automatic logic signed [MW:0] ext(input entry_type v);
      logic signed [MW:0] r;
      r = v;
      return r;
   endfunction

   function automatic entry_type clamp(input logic signed [MW:0] v);
      if (v[MW] != v[MW-1]) begin
         return v[MW] ? {1'b1, {(MW-1){1'b0}}} : {1'b0, {(MW-1){1'b1}}};
      end
      return v[MW-1:0];
   endfunction

   logic [FRONT_STAGES-1:0] valid_ff;
   logic [FRONT_STAGES-1:0] ready;
   coord_type         ctr_ff  [0:FRONT_STAGES-1][0:2];
   logic [DATA_W-1:0] size_ff [0:FRONT_STAGES-2][0:2];
   logic [TURN_W-1:0] turn    [0:5];
   entry_type         trig    [0:5];

   entry_type ta_ff, tb_ff, m00_ff, m10_ff, m20_ff, m21_ff, m22_ff;
   entry_type xa_ff, xb_ff, xc_ff, xd_ff, cy_ff, sy_ff;
   entry_type rm_ff [0:8];
   entry_type rm_in [0:8];
   half_type  h_ff  [0:8];
   half_type  h_in  [0:8];

   always_comb begin
      ready[FRONT_STAGES-1] = !valid_ff[FRONT_STAGES-1] || box_ready;
      for (int s = FRONT_STAGES - 2; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
   end

   assign req.ready = ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (ready & {valid_ff[FRONT_STAGES-2:0], req.valid}) | (~ready & valid_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         ctr_ff[0][0]  <= coord_type'($signed(req.data.center_x[CW-1:0]));
         ctr_ff[0][1]  <= coord_type'($signed(req.data.center_y[CW-1:0]));
         ctr_ff[0][2]  <= coord_type'($signed(req.data.center_z[CW-1:0]));
         size_ff[0][0] <= req.data.box_length;
         size_ff[0][1] <= req.data.box_width;
         size_ff[0][2] <= req.data.box_height;
      end
   end

   for (genvar s = 1; s < FRONT_STAGES; s++) begin : g_carry
      always_ff @(posedge clock) begin
         if (ready[s]) begin
            ctr_ff[s] <= ctr_ff[s-1];
         end
      end
      if (s < FRONT_STAGES - 1) begin : g_size
         always_ff @(posedge clock) begin
            if (ready[s]) begin
               size_ff[s] <= size_ff[s-1];
            end
         end
      end
   end

   always_comb begin
      turn[0] = turn_of(req.data.yaw_angle);
      turn[1] = turn_of(req.data.yaw_angle) + QUARTER_TURN;
      turn[2] = turn_of(req.data.pitch_angle);
      turn[3] = turn_of(req.data.pitch_angle) + QUARTER_TURN;
      turn[4] = turn_of(req.data.roll_angle);
      turn[5] = turn_of(req.data.roll_angle) + QUARTER_TURN;
   end

   for (genvar g = 0; g < 6; g++) begin : g_trig
      obc_sin u_sin (
         .clock    (clock),
         .stage_en (ready[SIN_STAGES-1:0]),
         .turn     (turn[g]),
         .sin_out  (trig[g])
      );
   end

   // trig holds, in order: sin yaw, cos yaw, sin pitch, cos pitch, sin roll, cos roll.
   always_ff @(posedge clock) begin
      if (ready[M1]) begin
         ta_ff  <= rmul(trig[4], trig[2]);
         tb_ff  <= rmul(trig[5], trig[2]);
         m00_ff <= rmul(trig[3], trig[1]);
         m10_ff <= rmul(trig[3], trig[0]);
         m20_ff <= -trig[2];
         m21_ff <= rmul(trig[4], trig[3]);
         m22_ff <= rmul(trig[5], trig[3]);
         xa_ff  <= rmul(trig[5], trig[0]);
         xb_ff  <= rmul(trig[5], trig[1]);
         xc_ff  <= rmul(trig[4], trig[0]);
         xd_ff  <= rmul(trig[4], trig[1]);
         cy_ff  <= trig[1];
         sy_ff  <= trig[0];
      end
   end

   always_comb begin
      rm_in[0] = clamp(ext(m00_ff));
      rm_in[1] = clamp(ext(rmul(ta_ff, cy_ff)) - ext(xa_ff));
      rm_in[2] = clamp(ext(rmul(tb_ff, cy_ff)) + ext(xc_ff));
      rm_in[3] = clamp(ext(m10_ff));
      rm_in[4] = clamp(ext(rmul(ta_ff, sy_ff)) + ext(xb_ff));
      rm_in[5] = clamp(ext(rmul(tb_ff, sy_ff)) - ext(xd_ff));
      rm_in[6] = clamp(ext(m20_ff));
      rm_in[7] = clamp(ext(m21_ff));
      rm_in[8] = clamp(ext(m22_ff));
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            logic [MW-1:0] mag_r;
            logic [AW-1:0] prod;
            logic [HW-2:0] mag_h;
            mag_r = rm_ff[i*3+j][MW-1] ? MW'(-rm_ff[i*3+j]) : MW'(rm_ff[i*3+j]);
            prod  = AW'(mag_r) * AW'(size_ff[FRONT_STAGES-2][j]) + HALF_RND;
            mag_h = (HW-1)'(prod >> (TRIG_FRAC_BITS + 1));
            h_in[i*3+j] = rm_ff[i*3+j][MW-1] ? -half_type'({1'b0, mag_h})
                                              : half_type'({1'b0, mag_h});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[M2]) begin
         rm_ff <= rm_in;
      end
      if (ready[M3]) begin
         h_ff <= h_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         box.ctr[i] = ctr_ff[FRONT_STAGES-1][i];
      end
      for (int n = 0; n < 9; n++) begin
         box.h[n] = h_ff[n];
      end
   end

   assign box_valid = valid_ff[FRONT_STAGES-1];
endmodule

@@ rtl/obc_corner.sv @@
`timescale 1ns / 1ps
`include "oriented_box_corners_top_defines.svh"
module obc_corner (
   input  logic             clock,
   input  logic             reset,
   input  logic             box_valid,
   output logic             box_ready,
   input  obc_pkg::box_type box,
   obc_rsp_if.source        rsp
);
   import obc_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) << (CW - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) << (CW - 1));

   logic    box_vld_ff;
   box_type box_ff;
   logic [2:0] k_ff;

   logic c1_vld_ff;
   logic [2:0] c1_k_ff;
   logic signed [SUM_W-1:0] sum_ff [0:2];
   logic signed [SUM_W-1:0] sum_in [0:2];

   logic c2_vld_ff;
   logic [2:0] c2_k_ff;
   logic c2_sat_ff;
   coord_type coord_ff [0:2];
   coord_type coord_in [0:2];
   logic sat_in;

   logic out_vld_ff;
   rsp_type out_ff;
   rsp_type out_in;
   coord_type mn_ff [0:2];
   coord_type mx_ff [0:2];
   coord_type mn_in [0:2];
   coord_type mx_in [0:2];

   logic out_ready, c2_ready, c1_ready, issue;

   assign out_ready = !out_vld_ff || rsp.ready;
   assign c2_ready  = !c2_vld_ff || out_ready;
   assign c1_ready  = !c1_vld_ff || c2_ready;
   assign issue     = box_vld_ff && c1_ready;
   assign box_ready = !box_vld_ff || (issue && k_ff == LAST_K);

   always_ff @(posedge clock) begin
      if (reset) begin
         box_vld_ff <= 1'b0;
         k_ff       <= '0;
         c1_vld_ff  <= 1'b0;
         c2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (box_ready) begin
            box_vld_ff <= box_valid;
         end
         if (issue) begin
            k_ff <= (k_ff == LAST_K) ? '0 : k_ff + 3'd1;
         end
         if (c1_ready) begin
            c1_vld_ff <= issue;
         end
         if (c2_ready) begin
            c2_vld_ff <= c1_vld_ff;
         end
         if (out_ready) begin
            out_vld_ff <= c2_vld_ff;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [SUM_W-1:0] acc;
         logic signed [SUM_W-1:0] term;
         acc = SUM_W'($signed(box_ff.ctr[i]));
         for (int j = 0; j < 3; j++) begin
            term = SUM_W'($signed(box_ff.h[i*3+j]));
            acc  = CORNER_POS[k_ff][j] ? acc + term : acc - term;
         end
         sum_in[i] = acc;
      end
   end

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (sum_ff[i] > SAT_HI) begin
            coord_in[i] = coord_type'(SAT_HI);
            sat_in      = 1'b1;
         end else if (sum_ff[i] < SAT_LO) begin
            coord_in[i] = coord_type'(SAT_LO);
            sat_in      = 1'b1;
         end else begin
            coord_in[i] = coord_type'(sum_ff[i]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mn_in[i] = (c2_k_ff == '0 || coord_ff[i] < mn_ff[i]) ? coord_ff[i] : mn_ff[i];
         mx_in[i] = (c2_k_ff == '0 || coord_ff[i] > mx_ff[i]) ? coord_ff[i] : mx_ff[i];
      end
      out_in.corner_index = c2_k_ff;
      out_in.corner_x     = coord_ff[0];
      out_in.corner_y     = coord_ff[1];
      out_in.corner_z     = coord_ff[2];
      out_in.last_corner  = (c2_k_ff == LAST_K);
      out_in.saturated    = c2_sat_ff;
      out_in.bound_x_min  = out_in.last_corner ? mn_in[0] : '0;
      out_in.bound_x_max  = out_in.last_corner ? mx_in[0] : '0;
      out_in.bound_y_min  = out_in.last_corner ? mn_in[1] : '0;
      out_in.bound_y_max  = out_in.last_corner ? mx_in[1] : '0;
      out_in.bound_z_min  = out_in.last_corner ? mn_in[2] : '0;
      out_in.bound_z_max  = out_in.last_corner ? mx_in[2] : '0;
   end

   always_ff @(posedge clock) begin
      if (box_ready && box_valid) begin
         box_ff <= box;
      end
      if (c1_ready) begin
         c1_k_ff <= k_ff;
         sum_ff  <= sum_in;
      end
      if (c2_ready) begin
         c2_k_ff   <= c1_k_ff;
         coord_ff  <= coord_in;
         c2_sat_ff <= sat_in;
      end
      if (out_ready && c2_vld_ff) begin
         out_ff <= out_in;
         mn_ff  <= mn_in;
         mx_ff  <= mx_in;
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.data  = out_ff;

   `OBC_ASSERT_NEXT(a_k_wrap, issue && k_ff == LAST_K, k_ff == '0, "corner count did not wrap")
   `OBC_ASSERT_NEXT(a_box_load, box_valid && box_ready, box_vld_ff && k_ff == '0, "box loaded mid-box")
   `OBC_ASSERT_NOW(a_bound_zero, rsp.valid && !rsp.data.last_corner, rsp.data.bound_x_min == '0 && rsp.data.bound_y_max == '0 && rsp.data.bound_z_max == '0, "bounds set before the last corner")
   `OBC_ASSERT_NOW(a_bound_order, rsp.valid && rsp.data.last_corner, rsp.data.bound_x_min <= rsp.data.corner_x && rsp.data.corner_x <= rsp.data.bound_x_max && rsp.data.bound_z_min <= rsp.data.bound_z_max, "bounds out of order")
endmodule

@@ rtl/oriented_box_corners_top.sv @@
`timescale 1ns / 1ps
// Channel    Port      Direction  Transfer carries
// request    req_chan  in         one box: center, roll, pitch, yaw, extents
// response   rsp_chan  out        one corner; the eighth also carries the bounds
//
// A box yields eight corners on the response port, one corner per cycle while the
// port does not stall, so the single result port limits throughput to one box per
// eight corner transfers. A request reaches the first corner through seven sine
// stages, three matrix stages, the corner sequencer and three corner stages.
// Reset is synchronous and clears only the valid bits and the corner counter.
// Any stall on the response port backs up through every stage without loss.
module oriented_box_corners_top (
   input logic        clock,
   input logic        reset,
   obc_req_if.sink    req_chan,
   obc_rsp_if.source  rsp_chan
);
   import obc_pkg::*;

   logic    box_valid;
   logic    box_ready;
   box_type box;

   obc_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .box_valid (box_valid),
      .box_ready (box_ready),
      .box       (box)
   );

   obc_corner u_corner (
      .clock     (clock),
      .reset     (reset),
      .box_valid (box_valid),
      .box_ready (box_ready),
      .box       (box),
      .rsp       (rsp_chan)
   );
endmodule

@@ tb/obc_tb_pkg.sv @@
`timescale 1ns / 1ps
package obc_tb_pkg;
   import obc_pkg::*;

   localparam int TRIG_F = obc_pkg::TRIG_FRAC_BITS;
   localparam int CWID   = obc_pkg::CW;

   function automatic longint corner_sine(input logic [31:0] u);
      logic [1:0] q;
      longint t, t2, p, s;
      int sh;
      q = u[31:30];
      t = longint'(u[29:0]);
      sh = (TRIG_F < 30) ? 30 - TRIG_F : 0;
      if (q[0]) t = (64'sd1 <<< 30) - t;
      t2 = (t * t) >>> 30;
      p = 172272;
      p = 5026995 - ((p * t2) >>> 30);
      p = 85569306 - ((p * t2) >>> 30);
      p = 693598668 - ((p * t2) >>> 30);
      p = 1686629713 - ((p * t2) >>> 30);
      s = (p * t) >>> 30;
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      if (sh > 0) s = (s + (64'sd1 <<< (sh - 1))) >>> sh;
      return q[1] ? -s : s;
   endfunction

   function automatic longint round_product(input longint a, input longint b);
      longint p, m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = (m + (64'sd1 <<< (TRIG_F - 1))) >>> TRIG_F;
      return (p < 0) ? -m : m;
   endfunction

   function automatic longint half_offset(input longint r, input longint sz, input bit neg_side);
      bit neg;
      logic [63:0] m;
      neg = (r < 0) != neg_side;
      m = (r < 0) ? -r : r;
      m = (m * sz + (64'd1 << TRIG_F)) >> (TRIG_F + 1);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   class corner_scoreboard;
      rsp_type pending[$];
      int errors;
      int boxes;
      int corners;
      int saturations;

      function void note_box(input req_type b);
         longint ctr[3], sz[3], rm[3][3], c, t, sy, cy, sp, cp, sr, cr;
         longint mn[3], mx[3], hi, lo, lim;
         logic [31:0] ay, ap, ar, keep;
         rsp_type r;
         bit sat;
         keep = ~((32'd1 << (32 - obc_pkg::ANGLE_BITS)) - 32'd1);
         ay = {b.yaw_angle, 16'd0} & keep;
         ap = {b.pitch_angle, 16'd0} & keep;
         ar = {b.roll_angle, 16'd0} & keep;
         ctr[0] = b.center_x; ctr[1] = b.center_y; ctr[2] = b.center_z;
         for (int i = 0; i < 3; i++) begin
            ctr[i] = (ctr[i] <<< (64 - CWID)) >>> (64 - CWID);
         end
         sz[0] = b.box_length; sz[1] = b.box_width; sz[2] = b.box_height;
         sy = corner_sine(ay); cy = corner_sine(ay + 32'h4000_0000);
         sp = corner_sine(ap); cp = corner_sine(ap + 32'h4000_0000);
         sr = corner_sine(ar); cr = corner_sine(ar + 32'h4000_0000);
         rm[0][0] = round_product(cp, cy);
         t = round_product(sr, sp);
         rm[0][1] = round_product(t, cy) - round_product(cr, sy);
         rm[1][1] = round_product(t, sy) + round_product(cr, cy);
         t = round_product(cr, sp);
         rm[0][2] = round_product(t, cy) + round_product(sr, sy);
         rm[1][2] = round_product(t, sy) - round_product(sr, cy);
         rm[1][0] = round_product(cp, sy);
         rm[2][0] = -sp;
         rm[2][1] = round_product(sr, cp);
         rm[2][2] = round_product(cr, cp);
         lim = 64'sd1 <<< (TRIG_F + 1);
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (rm[i][j] > lim - 1) rm[i][j] = lim - 1;
               if (rm[i][j] < -lim) rm[i][j] = -lim;
            end
         end
         hi = (64'sd1 <<< (CWID - 1)) - 1;
         lo = -(64'sd1 <<< (CWID - 1));
         for (int k = 0; k < 8; k++) begin
            r = '0;
            sat = 0;
            r.corner_index = 3'(k);
            for (int i = 0; i < 3; i++) begin
               c = ctr[i];
               for (int j = 0; j < 3; j++) begin
                  c += half_offset(rm[i][j], sz[j], !CORNER_POS[k][j]);
               end
               if (c > hi) begin c = hi; sat = 1; end
               if (c < lo) begin c = lo; sat = 1; end
               if (k == 0 || c < mn[i]) mn[i] = c;
               if (k == 0 || c > mx[i]) mx[i] = c;
               if (i == 0) r.corner_x = 32'(c);
               if (i == 1) r.corner_y = 32'(c);
               if (i == 2) r.corner_z = 32'(c);
            end
            if (k == 7) begin
               r.bound_x_min = 32'(mn[0]); r.bound_x_max = 32'(mx[0]);
               r.bound_y_min = 32'(mn[1]); r.bound_y_max = 32'(mx[1]);
               r.bound_z_min = 32'(mn[2]); r.bound_z_max = 32'(mx[2]);
               r.last_corner = 1'b1;
            end
            r.saturated = sat;
            pending.push_back(r);
         end
         boxes++;
      endfunction

      function void check_corner(input rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected corner transfer: %p", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         corners++;
         if (got.saturated) saturations++;
         if (got.corner_index !== e.corner_index) begin
            $error("corner_index expected %0d actual %0d", e.corner_index, got.corner_index);
            errors++;
         end
         if (got.corner_x !== e.corner_x) begin
            $error("corner_x expected %0d actual %0d", e.corner_x, got.corner_x);
            errors++;
         end
         if (got.corner_y !== e.corner_y) begin
            $error("corner_y expected %0d actual %0d", e.corner_y, got.corner_y);
            errors++;
         end
         if (got.corner_z !== e.corner_z) begin
            $error("corner_z expected %0d actual %0d", e.corner_z, got.corner_z);
            errors++;
         end
         if (got.bound_x_min !== e.bound_x_min) begin
            $error("bound_x_min expected %0d actual %0d", e.bound_x_min, got.bound_x_min);
            errors++;
         end
         if (got.bound_x_max !== e.bound_x_max) begin
            $error("bound_x_max expected %0d actual %0d", e.bound_x_max, got.bound_x_max);
            errors++;
         end
         if (got.bound_y_min !== e.bound_y_min) begin
            $error("bound_y_min expected %0d actual %0d", e.bound_y_min, got.bound_y_min);
            errors++;
         end
         if (got.bound_y_max !== e.bound_y_max) begin
            $error("bound_y_max expected %0d actual %0d", e.bound_y_max, got.bound_y_max);
            errors++;
         end
         if (got.bound_z_min !== e.bound_z_min) begin
            $error("bound_z_min expected %0d actual %0d", e.bound_z_min, got.bound_z_min);
            errors++;
         end
         if (got.bound_z_max !== e.bound_z_max) begin
            $error("bound_z_max expected %0d actual %0d", e.bound_z_max, got.bound_z_max);
            errors++;
         end
         if (got.last_corner !== e.last_corner) begin
            $error("last_corner expected %0d actual %0d", e.last_corner, got.last_corner);
            errors++;
         end
         if (got.saturated !== e.saturated) begin
            $error("saturated expected %0d actual %0d", e.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass
endpackage

@@ tb/tb_oriented_box_corners_top.sv @@
`timescale 1ns / 1ps
module tb_oriented_box_corners_top;
   import obc_pkg::*;
   import obc_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit stimulus_done = 0;
   corner_scoreboard board = new();

   obc_req_if req_chan();
   obc_rsp_if rsp_chan();

   oriented_box_corners_top dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) board.note_box(req_chan.data);
         if (rsp_chan.valid && rsp_chan.ready) board.check_corner(rsp_chan.data);
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
         2: return {$urandom_range(1) ? 16'h7FFF : 16'h8000, 16'($urandom)};
         default: return 32'($signed($urandom_range(200000)) - 100000);
      endcase
   endfunction

   function automatic logic [31:0] rand_extent();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(50)) << 16;
         2: return 32'hFFFF_0000 | 32'($urandom);
         default: return $urandom_range(4096);
      endcase
   endfunction

   task automatic send_box(input req_type b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      req_type b;
      repeat (count) begin
         b.center_x = rand_coord();
         b.center_y = rand_coord();
         b.center_z = rand_coord();
         b.yaw_angle = $urandom_range(3) == 0 ? 16'($urandom_range(4)) << 14 : 16'($urandom);
         b.pitch_angle = $urandom_range(3) == 0 ? 16'($urandom_range(4)) << 14 : 16'($urandom);
         b.roll_angle = $urandom_range(3) == 0 ? 16'($urandom_range(4)) << 14 : 16'($urandom);
         b.box_length = rand_extent();
         b.box_width = rand_extent();
         b.box_height = rand_extent();
         send_box(b);
      end
   endtask

   task automatic send_directed();
      req_type b;
      logic [15:0] angles [0:7];
      angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h8001,
                 16'h2000, 16'hFFFF};
      for (int i = 0; i < 8; i++) begin
         b.center_x = 32'h0001_0000 * i;
         b.center_y = -32'sh0002_0000;
         b.center_z = 32'h0000_8000;
         b.yaw_angle = angles[i];
         b.pitch_angle = angles[(i + 3) % 8];
         b.roll_angle = angles[(i + 5) % 8];
         b.box_length = 32'h0004_0000;
         b.box_width = 32'h0002_0001;
         b.box_height = 32'h0001_0003;
         send_box(b);
      end
      b = '0;
      send_box(b);
      b.center_x = 32'h7FFF_FFFF; b.center_y = 32'h8000_0000; b.center_z = 32'h7FFF_0000;
      b.box_length = 32'hFFFF_FFFF; b.box_width = 32'hFFFF_FFFF; b.box_height = 32'hFFFF_FFFF;
      b.yaw_angle = 16'h2000; b.pitch_angle = 16'hE000; b.roll_angle = 16'h1000;
      send_box(b);
      b.center_x = 32'h8000_0000; b.center_y = 32'h7FFF_FFFF; b.center_z = 32'h8000_0000;
      b.yaw_angle = 16'h8000; b.pitch_angle = 16'h7FFF; b.roll_angle = 16'h8000;
      send_box(b);
      b = '0;
      b.box_length = 32'hFFFF_FFFF;
      b.yaw_angle = 16'h1555;
      send_box(b);
      b.box_length = 32'd1; b.box_width = 32'd1; b.box_height = 32'd1;
      b.center_x = 32'hFFFF_FFFF; b.center_y = 32'h5555_5555; b.center_z = 32'hAAAA_AAAA;
      b.yaw_angle = 16'h5555; b.pitch_angle = 16'hAAAA; b.roll_angle = 16'h0001;
      send_box(b);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_directed();
      send_random(80);
      send_idle_pct = 62;
      send_random(70);
      send_idle_pct = 0;
      recv_stall_pct = 62;
      send_random(70);
      send_idle_pct = 14;
      recv_stall_pct = 14;
      send_random(70);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_random(67);
      req_chan.valid <= 1'b0;
      stimulus_done = 1;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("Run covered %0d boxes and %0d corners, %0d of them saturated.",
               board.boxes, board.corners, board.saturations);
      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Timeout with %0d corners still outstanding.", board.pending.size());
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
